// ===== src/epsg_pkg.sv =====
// Shared types, constants and the half-sine table for the pulse sample generator.
package epsg_pkg;

  localparam int MAX_SAMPLES = 100;
  localparam int DAC_BITS    = 12;
  localparam int DAC_MAX     = (1 << DAC_BITS) - 1;

  localparam int AMP_W  = 12;
  localparam int TICK_W = 32;
  localparam int PROD_W = TICK_W + AMP_W;
  localparam int DIV_STEPS = AMP_W;

  localparam int RECIP_SHIFT = 24;

  localparam int N_8   = 8;
  localparam int N_20  = 20;
  localparam int N_50  = 50;

  localparam int BASE_20  = N_8;
  localparam int BASE_50  = N_8 + N_20;
  localparam int BASE_MAX = N_8 + N_20 + N_50;
  localparam int TAB_LEN  = BASE_MAX + MAX_SAMPLES;
  localparam int TAB_W    = $clog2(TAB_LEN);

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned SIN_ONE = 64'd65536;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_SQUARE = 2'd1,
    SHAPE_TRI    = 2'd2,
    SHAPE_SAW    = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    CFG_WAVE_SHAPE      = 3'd0,
    CFG_PULSE_WIDTH     = 3'd1,
    CFG_PEAK_AMPLITUDE  = 3'd2,
    CFG_ENVELOPE_ENABLE = 3'd3,
    CFG_RAMP_IN_TICKS   = 3'd4,
    CFG_RAMP_OUT_TICKS  = 3'd5,
    CFG_ENVELOPE_LENGTH = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    AMP_PEAK = 2'd0,
    AMP_ZERO = 2'd1,
    AMP_RAMP = 2'd2
  } amp_mode_t;

  typedef struct packed {
    logic [31:0] elapsed_ticks;
    logic [6:0]  sample_index;
  } item_t;

  typedef struct packed {
    logic [11:0] sample_value;
    logic [11:0] current_amplitude;
    logic        envelope_done;
    logic [6:0]  sample_count;
    logic        last_sample;
  } result_t;

  typedef struct packed {
    shape_t              wave_shape;
    logic [15:0]         pulse_width;
    logic [AMP_W-1:0]    peak_amplitude;
    logic                envelope_enable;
    logic [TICK_W-1:0]   ramp_in_ticks;
    logic [TICK_W-1:0]   ramp_out_ticks;
    logic [TICK_W-1:0]   envelope_length;
  } cfg_t;

  // Per-item control that rides along the envelope divider.
  typedef struct packed {
    logic       done;
    amp_mode_t  amode;
    logic [1:0] nsel;
    logic [6:0] idx;
  } side_t;

  localparam logic [7:0] N_TAB [4] = '{8'(N_8), 8'(N_20), 8'(N_50), 8'(MAX_SAMPLES)};
  localparam logic [TAB_W-1:0] BASE_TAB [4] =
    '{TAB_W'(0), TAB_W'(BASE_20), TAB_W'(BASE_50), TAB_W'(BASE_MAX)};
  localparam logic [21:0] RECIP_TAB [4] = '{
    22'((1 << RECIP_SHIFT) / N_8),
    22'((1 << RECIP_SHIFT) / N_20),
    22'((1 << RECIP_SHIFT) / N_50),
    22'((1 << RECIP_SHIFT) / MAX_SAMPLES)
  };

  typedef logic [16:0] sine_tab_t [TAB_LEN];

  // sin(pi * x) for x in Q16, evaluated with truncated Q30 products.
  function automatic logic [16:0] half_sine_q16(longint unsigned x_in);
    longint unsigned x, xf, t, t2, u, s;
    x = (x_in > SIN_ONE) ? SIN_ONE : x_in;
    xf = (x <= SIN_ONE / 2) ? x : SIN_ONE - x;
    t  = (xf * PI_Q30) >> 16;
    t2 = (t * t) >> 30;
    u  = Q30_ONE - t2 / 72;
    u  = Q30_ONE - ((t2 * u) >> 30) / 42;
    u  = Q30_ONE - ((t2 * u) >> 30) / 20;
    u  = Q30_ONE - ((t2 * u) >> 30) / 6;
    s  = (t * u) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > SIN_ONE) s = SIN_ONE;
    return 17'(s);
  endfunction

  // One segment per sample count, laid out back to back.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned i, x;
    for (int k = 0; k < TAB_LEN; k++) begin
      if (k < BASE_20) begin
        i = longint'(k);
        x = (i * SIN_ONE) / (N_8 - 1);
      end else if (k < BASE_50) begin
        i = longint'(k - BASE_20);
        x = (i * SIN_ONE) / (N_20 - 1);
      end else if (k < BASE_MAX) begin
        i = longint'(k - BASE_50);
        x = (i * SIN_ONE) / (N_50 - 1);
      end else begin
        i = longint'(k - BASE_MAX);
        x = (i * SIN_ONE) / (MAX_SAMPLES - 1);
      end
      tab[k] = half_sine_q16(x);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== src/epsg_env.sv =====
// Input register and envelope decision: picks the ramp and forms its numerator product.
module epsg_env import epsg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cfg_t                cfg,
  input  logic                in_valid,
  input  item_t               in_item,
  output logic                valid,
  output logic [PROD_W-1:0]   prod,
  output logic [TICK_W-1:0]   den,
  output side_t               side
);

  logic              v0;
  logic [TICK_W-1:0] t0;
  logic [6:0]        i0;

  logic [TICK_W-1:0] num;
  logic [TICK_W-1:0] den_sel;
  logic [TICK_W-1:0] left;
  side_t             side_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v0    <= in_valid;
      valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0   <= in_item.elapsed_ticks;
      i0   <= in_item.sample_index;
      prod <= PROD_W'(num) * PROD_W'(cfg.peak_amplitude);
      den  <= den_sel;
      side <= side_sel;
    end
  end

  always_comb begin
    left           = cfg.envelope_length - t0;
    num            = t0;
    den_sel        = cfg.ramp_in_ticks;
    side_sel.done  = 1'b0;
    side_sel.amode = AMP_PEAK;
    side_sel.idx   = i0;
    if (cfg.pulse_width > 16'd50)      side_sel.nsel = 2'd3;
    else if (cfg.pulse_width > 16'd10) side_sel.nsel = 2'd2;
    else if (cfg.pulse_width > 16'd3)  side_sel.nsel = 2'd1;
    else                               side_sel.nsel = 2'd0;
    if (cfg.envelope_enable) begin
      if (t0 > cfg.envelope_length) begin
        side_sel.done  = 1'b1;
        side_sel.amode = AMP_ZERO;
      end else if (t0 < cfg.ramp_in_ticks) begin
        side_sel.amode = AMP_RAMP;
      end else if (left < cfg.ramp_out_ticks) begin
        // On the falling ramp the remaining time is below the ramp length.
        side_sel.amode = AMP_RAMP;
        num            = left;
        den_sel        = cfg.ramp_out_ticks;
      end
    end
  end

endmodule

// ===== src/epsg_div.sv =====
// Pipelined restoring divider: one quotient bit of the ramp amplitude per stage.
module epsg_div import epsg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [PROD_W-1:0]   prod,
  input  logic [TICK_W-1:0]   den,
  input  side_t               in_side,
  output logic                valid,
  output logic [AMP_W-1:0]    quo,
  output side_t               side
);

  logic [DIV_STEPS-1:0] v;
  logic [TICK_W-1:0]    rem  [DIV_STEPS];
  logic [AMP_W-1:0]     low  [DIV_STEPS];
  logic [AMP_W-1:0]     q    [DIV_STEPS];
  logic [TICK_W-1:0]    dv   [DIV_STEPS];
  side_t                sd   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic              v_in;
    logic [TICK_W-1:0] r_in;
    logic [AMP_W-1:0]  low_in;
    logic [AMP_W-1:0]  q_in;
    logic [TICK_W-1:0] d_in;
    side_t             s_in;
    logic [TICK_W:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      // The upper part of the product is already below the divisor.
      assign v_in   = in_valid;
      assign r_in   = prod[PROD_W-1:AMP_W];
      assign low_in = prod[AMP_W-1:0];
      assign q_in   = '0;
      assign d_in   = den;
      assign s_in   = in_side;
    end else begin : g_rest
      assign v_in   = v[k-1];
      assign r_in   = rem[k-1];
      assign low_in = low[k-1];
      assign q_in   = q[k-1];
      assign d_in   = dv[k-1];
      assign s_in   = sd[k-1];
    end

    assign trial = {r_in, low_in[AMP_W-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? TICK_W'(trial - {1'b0, d_in}) : trial[TICK_W-1:0];
        low[k] <= {low_in[AMP_W-2:0], 1'b0};
        q[k]   <= {q_in[AMP_W-2:0], ge};
        dv[k]  <= d_in;
        sd[k]  <= s_in;
      end
    end
  end

  assign valid = v[DIV_STEPS-1];
  assign quo   = q[DIV_STEPS-1];
  assign side  = sd[DIV_STEPS-1];

endmodule

// ===== src/epsg_shape.sv =====
// Waveform back end: table lookup, shape products, divide by sample count, shape select.
module epsg_shape import epsg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [AMP_W-1:0]  quo,
  input  side_t             in_side,
  output logic              valid,
  output result_t           res
);

  // Stage 1: amplitude, table value, a*(n-i-1).
  logic              v1, act1, last1, done1;
  logic [AMP_W-1:0]  a1;
  logic [16:0]       s1;
  logic [19:0]       p1;
  logic [1:0]        ns1;
  // Stage 2: products.
  logic              v2, act2, last2, done2;
  logic [AMP_W-1:0]  a2;
  logic [28:0]       sp2;
  logic [41:0]       pm2;
  logic [19:0]       p2;
  logic [1:0]        ns2;
  // Stage 3: corrected quotient.
  logic              v3, act3, last3, done3;
  logic [AMP_W-1:0]  a3;
  logic [12:0]       sv3;
  logic [AMP_W-1:0]  q3;
  logic [1:0]        ns3;

  logic [AMP_W-1:0]  a_c;
  logic [7:0]        n_c;
  logic [7:0]        i_c;
  logic [7:0]        m_c;
  logic [TAB_W:0]    ti_c;
  logic [16:0]       s_c;
  logic              act_c;

  logic [AMP_W-1:0]  q0;
  logic [19:0]       r_c;
  logic [AMP_W-1:0]  qc;

  logic [10:0]       half;
  logic [AMP_W-1:0]  dif;
  logic [12:0]       dif2;
  logic [12:0]       v_c;
  logic [7:0]        n3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    unique case (in_side.amode)
      AMP_PEAK: a_c = cfg.peak_amplitude;
      AMP_ZERO: a_c = '0;
      AMP_RAMP: a_c = quo;
      default:  a_c = cfg.peak_amplitude;
    endcase
    n_c   = N_TAB[in_side.nsel];
    i_c   = {1'b0, in_side.idx};
    act_c = !in_side.done && ((i_c + 8'd1) < n_c);
    m_c   = n_c - i_c - 8'd1;
    ti_c  = (TAB_W+1)'(BASE_TAB[in_side.nsel]) + (TAB_W+1)'(in_side.idx);
    s_c   = (act_c && ti_c < (TAB_W+1)'(TAB_LEN)) ? SINE_TAB[ti_c[TAB_W-1:0]] : '0;
  end

  always_comb begin
    q0  = pm2[RECIP_SHIFT+AMP_W-1:RECIP_SHIFT];
    r_c = p2 - 20'(q0) * 20'(N_TAB[ns2]);
    // The reciprocal estimate is at most one below the true quotient.
    qc  = (r_c >= 20'(N_TAB[ns2])) ? q0 + AMP_W'(1) : q0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= a_c;
      s1    <= s_c;
      p1    <= 20'(a_c) * 20'(m_c);
      ns1   <= in_side.nsel;
      act1  <= act_c;
      last1 <= (i_c + 8'd1) == n_c;
      done1 <= in_side.done;

      a2    <= a1;
      sp2   <= 29'(a1) * 29'(s1);
      pm2   <= 42'(p1) * 42'(RECIP_TAB[ns1]);
      p2    <= p1;
      ns2   <= ns1;
      act2  <= act1;
      last2 <= last1;
      done2 <= done1;

      a3    <= a2;
      sv3   <= sp2[28:16];
      q3    <= qc;
      ns3   <= ns2;
      act3  <= act2;
      last3 <= last2;
      done3 <= done2;
    end
  end

  always_comb begin
    half = a3[AMP_W-1:1];
    dif  = (AMP_W'(half) > q3) ? AMP_W'(half) - q3 : q3 - AMP_W'(half);
    dif2 = {dif, 1'b0};
    v_c  = '0;
    if (act3) begin
      case (cfg.wave_shape)
        SHAPE_SINE:   v_c = sv3;
        SHAPE_SQUARE: v_c = 13'(a3);
        SHAPE_TRI:    v_c = (dif2 > 13'(a3)) ? 13'd0 : 13'(a3) - dif2;
        default:      v_c = 13'(a3) - 13'(q3);
      endcase
    end
    n3 = N_TAB[ns3];
    res.sample_value      = ({4'd0, v_c} > 17'(DAC_MAX)) ? 12'(DAC_MAX) : v_c[11:0];
    res.current_amplitude = a3;
    res.envelope_done     = done3;
    res.sample_count      = n3[6:0];
    res.last_sample       = last3;
  end

  assign valid = v3;

endmodule

// ===== src/enveloped_pulse_sample_generator_core.sv =====
// Top level of the enveloped pulse sample generator: registers, pipeline and output register.
//
//   channel  direction  handshake             payload
//   item     in         item_valid/item_stall  item_t   (elapsed_ticks, sample_index)
//   result   out        result_valid/result_stall result_t
//   cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One item is taken every cycle while item_stall is low. Pipeline: input register, product
// register, the 12-stage restoring divider that forms the ramp amplitude, three waveform
// stages and the output register. Reset is synchronous and clears all valid bits and the
// configuration registers to their defaults. A stall on the result side while result_valid
// is high freezes the whole pipeline and is passed back to item_stall the same cycle.
module enveloped_pulse_sample_generator_core import epsg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t              cfg;
  logic              adv;

  logic              env_valid;
  logic [PROD_W-1:0] env_prod;
  logic [TICK_W-1:0] env_den;
  side_t             env_side;

  logic              div_valid;
  logic [AMP_W-1:0]  div_quo;
  side_t             div_side;

  logic              shp_valid;
  result_t           shp_res;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_shape      <= SHAPE_SINE;
      cfg.pulse_width     <= 16'd50;
      cfg.peak_amplitude  <= '0;
      cfg.envelope_enable <= 1'b0;
      cfg.ramp_in_ticks   <= '0;
      cfg.ramp_out_ticks  <= '0;
      cfg.envelope_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WAVE_SHAPE:      cfg.wave_shape      <= shape_t'(cfg_data[1:0]);
        CFG_PULSE_WIDTH:     cfg.pulse_width     <= cfg_data[15:0];
        CFG_PEAK_AMPLITUDE:  cfg.peak_amplitude  <= cfg_data[AMP_W-1:0];
        CFG_ENVELOPE_ENABLE: cfg.envelope_enable <= cfg_data[0];
        CFG_RAMP_IN_TICKS:   cfg.ramp_in_ticks   <= cfg_data;
        CFG_RAMP_OUT_TICKS:  cfg.ramp_out_ticks  <= cfg_data;
        CFG_ENVELOPE_LENGTH: cfg.envelope_length <= cfg_data;
        default: ;
      endcase
    end
  end

  epsg_env u_env (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .cfg      (cfg),
    .in_valid (item_valid),
    .in_item  (item),
    .valid    (env_valid),
    .prod     (env_prod),
    .den      (env_den),
    .side     (env_side)
  );

  epsg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (env_valid),
    .prod     (env_prod),
    .den      (env_den),
    .in_side  (env_side),
    .valid    (div_valid),
    .quo      (div_quo),
    .side     (div_side)
  );

  epsg_shape u_shape (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .cfg      (cfg),
    .in_valid (div_valid),
    .quo      (div_quo),
    .in_side  (div_side),
    .valid    (shp_valid),
    .res      (shp_res)
  );

  // Output register; a transfer or an empty slot lets the pipeline move.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= shp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= shp_res;
    end
  end

endmodule
